[rtl/thsr_pkg.sv]
// ----------------------------------------------------------------------------
// thsr_pkg
// Shared types and constants for the tuple hash segment reducer.
// ----------------------------------------------------------------------------
`default_nettype none

package thsr_pkg;

  // field widths
  localparam int KEY_W   = 32;
  localparam int SEG_W   = 12;
  localparam int NSEG_W  = 13;
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 8;
  localparam int CDATA_W = 16;
  localparam int OUT_W   = 48;

  // jump hash arithmetic
  localparam logic [63:0] JUMP_MULT  = 64'd2862933555777941757;
  localparam int          JUMP_SHIFT = 33;
  localparam int          JUMP_SCALE = 31;
  // dividend: 13-bit (b+1) scaled by 2^31
  localparam int          DIV_W      = NSEG_W + JUMP_SCALE;
  localparam int          CNT_W      = 6;

  localparam int DEF_MAX_SEGMENTS = 4096;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SEG_COUNT   = 8'd0;
  localparam logic [IDX_W-1:0] REG_REDUCE_MODE = 8'd1;

  // reduce modes
  localparam logic [MODE_W-1:0] MODE_JUMP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MASK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MOD  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_DLOAD,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    SEG_MASK,
    SEG_JUMP,
    SEG_MOD
  } seg_src_t;

  typedef struct packed {
    logic     accept;
    logic     mul0;
    logic     mul1;
    logic     mul2;
    logic     div_load;
    logic     div_mod;
    logic     div_step;
    logic     b_load;
    logic     out_load;
    seg_src_t seg_src;
  } ctrl_t;

  typedef struct packed {
    logic              last;
    logic [MODE_W-1:0] mode;
    logic              j_lt_n;
    logic              div_last;
    logic              out_free;
  } stat_t;

endpackage

`default_nettype wire

[rtl/thsr_ctrl.sv]
// ----------------------------------------------------------------------------
// thsr_ctrl
// Sequencer: attribute beats, jump hash loop, modulo pass, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module thsr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire thsr_pkg::stat_t stat,
  output thsr_pkg::ctrl_t      ctrl
);

  thsr_pkg::state_t   state, state_next;
  thsr_pkg::seg_src_t src, src_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= thsr_pkg::ST_IDLE;
      src   <= thsr_pkg::SEG_JUMP;
    end else begin
      state <= state_next;
      src   <= src_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    src_next   = src;
    case (state)
      thsr_pkg::ST_IDLE: begin
        if (s_tvalid && stat.last) begin
          if (stat.mode == thsr_pkg::MODE_MASK) begin
            src_next   = thsr_pkg::SEG_MASK;
            state_next = thsr_pkg::ST_FINISH;
          end else if (stat.mode == thsr_pkg::MODE_MOD) begin
            src_next   = thsr_pkg::SEG_MOD;
            state_next = thsr_pkg::ST_DLOAD;
          end else begin
            src_next   = thsr_pkg::SEG_JUMP;
            state_next = thsr_pkg::ST_CHECK;
          end
        end
      end
      thsr_pkg::ST_CHECK: begin
        state_next = stat.j_lt_n ? thsr_pkg::ST_MUL0 : thsr_pkg::ST_FINISH;
      end
      thsr_pkg::ST_MUL0:  state_next = thsr_pkg::ST_MUL1;
      thsr_pkg::ST_MUL1:  state_next = thsr_pkg::ST_MUL2;
      thsr_pkg::ST_MUL2:  state_next = thsr_pkg::ST_DLOAD;
      thsr_pkg::ST_DLOAD: state_next = thsr_pkg::ST_DIV;
      thsr_pkg::ST_DIV: begin
        if (stat.div_last) begin
          state_next = (src == thsr_pkg::SEG_MOD) ? thsr_pkg::ST_FINISH
                                                   : thsr_pkg::ST_CHECK;
        end
      end
      thsr_pkg::ST_FINISH: begin
        if (stat.out_free) state_next = thsr_pkg::ST_IDLE;
      end
      default: state_next = thsr_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    ctrl          = '0;
    ctrl.seg_src  = src;
    ctrl.div_mod  = (src == thsr_pkg::SEG_MOD);
    s_tready      = 1'b0;
    case (state)
      thsr_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        ctrl.accept = s_tvalid;
      end
      thsr_pkg::ST_CHECK:  ctrl.b_load   = stat.j_lt_n;
      thsr_pkg::ST_MUL0:   ctrl.mul0     = 1'b1;
      thsr_pkg::ST_MUL1:   ctrl.mul1     = 1'b1;
      thsr_pkg::ST_MUL2:   ctrl.mul2     = 1'b1;
      thsr_pkg::ST_DLOAD:  ctrl.div_load = 1'b1;
      thsr_pkg::ST_DIV:    ctrl.div_step = 1'b1;
      thsr_pkg::ST_FINISH: ctrl.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/thsr_dp.sv]
// ----------------------------------------------------------------------------
// thsr_dp
// Datapath: key mixing, config registers, 64-bit jump state multiply,
// shared restoring divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module thsr_dp #(
  parameter int MAX_SEGMENTS = thsr_pkg::DEF_MAX_SEGMENTS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  input  wire logic [thsr_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [thsr_pkg::CDATA_W-1:0] cfg_data,
  input  wire logic [thsr_pkg::KEY_W-1:0]   attr_hash,
  input  wire logic                        is_null,
  input  wire logic                        last_attribute,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [thsr_pkg::OUT_W-1:0]        m_tdata,
  input  wire thsr_pkg::ctrl_t             ctrl,
  output thsr_pkg::stat_t                  stat
);

  localparam logic [16:0] MAX_N = 17'(MAX_SEGMENTS);

  logic [thsr_pkg::NSEG_W-1:0] seg_cfg;
  logic [thsr_pkg::MODE_W-1:0] reduce_mode;
  logic [thsr_pkg::KEY_W-1:0]  running_key, key_mixed, tkey;
  logic [16:0]                 n_wide;
  logic [thsr_pkg::NSEG_W-1:0] n_eff, b;
  logic [63:0]                 st, prod;
  logic [31:0]                 acc;
  logic [63:0]                 mul_a, mul_b;
  logic [thsr_pkg::DIV_W-1:0]  num;
  logic [31:0]                 den, rem;
  logic [32:0]                 r2;
  logic                        r_ge;
  logic [thsr_pkg::CNT_W-1:0]  cnt;
  logic [thsr_pkg::SEG_W-1:0]  seg_sel;
  logic [thsr_pkg::NSEG_W-1:0] n_m1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_cfg     <= thsr_pkg::NSEG_W'(1);
      reduce_mode <= thsr_pkg::MODE_JUMP;
    end else if (cfg_valid) begin
      if (cfg_index == thsr_pkg::REG_SEG_COUNT)
        seg_cfg <= cfg_data[thsr_pkg::NSEG_W-1:0];
      else if (cfg_index == thsr_pkg::REG_REDUCE_MODE)
        reduce_mode <= cfg_data[thsr_pkg::MODE_W-1:0];
    end
  end

  // effective segment count, clamped to 1..MAX_SEGMENTS
  always_comb begin
    n_wide = {4'd0, seg_cfg};
    if (n_wide == 17'd0) n_wide = 17'd1;
    if (n_wide > MAX_N) n_wide = MAX_N;
    n_eff = n_wide[thsr_pkg::NSEG_W-1:0];
  end

  // rotate and mix
  always_comb begin
    key_mixed = {running_key[thsr_pkg::KEY_W-2:0], running_key[thsr_pkg::KEY_W-1]};
    if (!is_null) key_mixed = key_mixed ^ attr_hash;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_key <= '0;
    end else if (ctrl.accept) begin
      running_key <= last_attribute ? '0 : key_mixed;
    end
  end

  // 64x64 multiply mod 2^64 as three 32x32 partial products
  assign mul_a = 64'(st[31:0])  * 64'(thsr_pkg::JUMP_MULT[31:0]);
  assign mul_b = (ctrl.mul1 ? 64'(st[63:32]) : 64'(st[31:0]))
               * (ctrl.mul1 ? 64'(thsr_pkg::JUMP_MULT[31:0])
                            : 64'(thsr_pkg::JUMP_MULT[63:32]));

  // restoring divider step
  assign r2   = {rem, num[thsr_pkg::DIV_W-1]};
  assign r_ge = (r2 >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (ctrl.accept && last_attribute) begin
      tkey <= key_mixed;
      st   <= 64'(key_mixed);
      num  <= '0;
      b    <= '0;
    end
    if (ctrl.b_load) b <= num[thsr_pkg::NSEG_W-1:0];
    if (ctrl.mul0) prod <= mul_a;
    if (ctrl.mul1) acc  <= prod[63:32] + mul_b[31:0];
    if (ctrl.mul2) st   <= {acc + mul_b[31:0], prod[31:0]} + 64'd1;
    if (ctrl.div_load) begin
      rem <= '0;
      cnt <= '0;
      if (ctrl.div_mod) begin
        num <= thsr_pkg::DIV_W'(tkey);
        den <= 32'(n_eff);
      end else begin
        num <= {b + thsr_pkg::NSEG_W'(1), {thsr_pkg::JUMP_SCALE{1'b0}}};
        den <= 32'(st[63:thsr_pkg::JUMP_SHIFT]) + 32'd1;
      end
    end
    if (ctrl.div_step) begin
      cnt <= cnt + thsr_pkg::CNT_W'(1);
      rem <= r_ge ? 32'(r2 - {1'b0, den}) : r2[31:0];
      num <= {num[thsr_pkg::DIV_W-2:0], r_ge};
    end
  end

  // segment select
  assign n_m1 = n_eff - thsr_pkg::NSEG_W'(1);
  always_comb begin
    case (ctrl.seg_src)
      thsr_pkg::SEG_MASK: seg_sel = tkey[thsr_pkg::SEG_W-1:0] & n_m1[thsr_pkg::SEG_W-1:0];
      thsr_pkg::SEG_MOD:  seg_sel = rem[thsr_pkg::SEG_W-1:0];
      default:            seg_sel = b[thsr_pkg::SEG_W-1:0];
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) m_tdata <= {4'd0, tkey, seg_sel};
  end

  // status
  assign stat.last     = last_attribute;
  assign stat.mode     = reduce_mode;
  assign stat.j_lt_n   = (num < thsr_pkg::DIV_W'(n_eff));
  assign stat.div_last = (cnt == thsr_pkg::CNT_W'(thsr_pkg::DIV_W - 1));
  assign stat.out_free = !m_tvalid || m_tready;

endmodule

`default_nettype wire

[rtl/tuple_hash_segment_reducer.sv]
// ----------------------------------------------------------------------------
// tuple_hash_segment_reducer
// Folds attribute hashes into a tuple key and maps it to a segment.
// ----------------------------------------------------------------------------
// Each attribute beat rotates the running key left by one and XORs in the
// hash unless tuser (null) is set. The tlast beat ends the tuple: the key
// is reduced and one result beat is produced. Mask mode goes straight to
// the output register, modulo mode makes one divider pass, and jump hash
// mode loops, where each iteration is three 32x32 partial products for
// the 64-bit state update plus a one-bit-per-cycle 44-bit restoring
// divider; the iteration count grows about as the log of the segment
// count. A finished result waits in the output register while new beats
// come in.
// ----------------------------------------------------------------------------
`default_nettype none

module tuple_hash_segment_reducer #(
  parameter int MAX_SEGMENTS = thsr_pkg::DEF_MAX_SEGMENTS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // config write channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [thsr_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [thsr_pkg::CDATA_W-1:0] cfg_data,
  // input stream
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [thsr_pkg::KEY_W-1:0]   s_tdata,  // [31:0] attr_hash
  input  wire logic                        s_tuser,  // [0] is_null
  input  wire logic                        s_tlast,  // last_attribute
  // result stream
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [thsr_pkg::OUT_W-1:0]        m_tdata   // [11:0] segment, [43:12] tuple_key
);

  thsr_pkg::ctrl_t ctrl;
  thsr_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  thsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  thsr_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .attr_hash      (s_tdata),
    .is_null        (s_tuser),
    .last_attribute (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .ctrl           (ctrl),
    .stat           (stat)
  );

`ifndef SYNTHESIS
  // attribute beats never stall the input
  a_attr_one_cycle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast |=> s_tready)
    else $error("attribute beat stalled input");

  // mask mode result reaches the output register via the finish state after tlast
  a_mask_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast && !m_tvalid &&
    (stat.mode == thsr_pkg::MODE_MASK) |-> ##2 m_tvalid)
    else $error("mask mode result late");

  // no result is loaded while the block is taking beats
  a_no_load_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !ctrl.out_load)
    else $error("output load while idle");
`endif

endmodule

`default_nettype wire
